FILE: src/linear_block_code_single_error_locator_top_defines.svh
// ----------------------------------------------------------------------------
// linear block code single error locator: assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLOCK_CODE_SINGLE_ERROR_LOCATOR_TOP_DEFINES_SVH
`define LINEAR_BLOCK_CODE_SINGLE_ERROR_LOCATOR_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LBCSEL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LBCSEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lbcsel_pkg.sv
// ----------------------------------------------------------------------------
// lbcsel_pkg
// sizes, word types and helpers for the single error locator
// ----------------------------------------------------------------------------
package lbcsel_pkg;

    localparam int DATA_BITS   = 11;
    localparam int CHECK_BITS  = 4;
    localparam int CODE_BITS   = DATA_BITS + CHECK_BITS;
    localparam int MATRIX_BITS = DATA_BITS * CHECK_BITS;
    localparam int FLIP_BITS   = 4;
    localparam int POS_BITS    = 5;

    typedef logic [MATRIX_BITS-1:0] matrix_t;
    typedef logic [CHECK_BITS-1:0]  check_t;
    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [POS_BITS-1:0]    pos_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] data_word;
        logic [FLIP_BITS-1:0] flip_position;
    } item_t;

    typedef struct packed {
        code_t  codeword;
        code_t  received_word;
        check_t syndrome;
    } coded_t;

    typedef struct packed {
        code_t  codeword;
        code_t  received_word;
        check_t syndrome;
        pos_t   error_position;
    } result_t;

    // row j of the parity part of the generator
    function automatic check_t row_of(input matrix_t m, input int j);
        return m[j*CHECK_BITS +: CHECK_BITS];
    endfunction

endpackage

FILE: src/lbcsel_encode.sv
// ----------------------------------------------------------------------------
// lbcsel_encode
// systematic encoder, single bit inversion and syndrome of the received word
// ----------------------------------------------------------------------------
module lbcsel_encode
    import lbcsel_pkg::*;
(
    input  matrix_t parity_matrix,
    input  item_t   item,
    output coded_t  coded
);

    function automatic check_t parity_of(input matrix_t m, input logic [DATA_BITS-1:0] d);
        check_t acc;
        acc = '0;
        for (int j = 0; j < DATA_BITS; j++)
        begin
            if (d[j])
            begin
                acc = acc ^ row_of(m, j);
            end
        end
        return acc;
    endfunction

    check_t parity;
    code_t  code;
    pos_t   flip_sat;
    code_t  flip_mask;
    code_t  recv;
    pos_t   flip_ext;

    assign parity   = parity_of(parity_matrix, item.data_word);
    assign code     = {parity, item.data_word};
    assign flip_ext = {{(POS_BITS-FLIP_BITS){1'b0}}, item.flip_position};

    // zero counts as the first bit, anything past the word as the last
    always_comb
    begin
        priority if (flip_ext == '0)
        begin
            flip_sat = POS_BITS'(1);
        end
        else if (flip_ext > POS_BITS'(CODE_BITS))
        begin
            flip_sat = POS_BITS'(CODE_BITS);
        end
        else
        begin
            flip_sat = flip_ext;
        end
    end

    always_comb
    begin
        for (int b = 0; b < CODE_BITS; b++)
        begin
            flip_mask[b] = (flip_sat == POS_BITS'(b + 1));
        end
    end

    assign recv = code ^ flip_mask;

    assign coded.codeword      = code;
    assign coded.received_word = recv;
    assign coded.syndrome      = parity_of(parity_matrix, recv[DATA_BITS-1:0])
                                 ^ recv[CODE_BITS-1:DATA_BITS];

endmodule

FILE: src/lbcsel_locate.sv
// ----------------------------------------------------------------------------
// lbcsel_locate
// finds the first check matrix column equal to the syndrome
// ----------------------------------------------------------------------------
module lbcsel_locate
    import lbcsel_pkg::*;
(
    input  matrix_t parity_matrix,
    input  check_t  syndrome,
    output pos_t    error_position
);

    // walk from the top so the lowest matching column wins, data columns first
    always_comb
    begin
        error_position = POS_BITS'(CODE_BITS + 1);
        for (int j = CHECK_BITS - 1; j >= 0; j--)
        begin
            if (syndrome == (CHECK_BITS'(1) << j))
            begin
                error_position = POS_BITS'(DATA_BITS + j + 1);
            end
        end
        for (int j = DATA_BITS - 1; j >= 0; j--)
        begin
            if (row_of(parity_matrix, j) == syndrome)
            begin
                error_position = POS_BITS'(j + 1);
            end
        end
    end

endmodule

FILE: src/linear_block_code_single_error_locator_top.sv
// ----------------------------------------------------------------------------
// linear_block_code_single_error_locator_top
// encodes a data word, inverts one bit and locates it from the syndrome
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  item      item_valid / item_stall   item   (data_word, flip_position)
//  result    result_valid / result_stall  result (codeword, received_word,
//                                              syndrome, error_position)
//  cfg       cfg_write                 cfg_data (parity_matrix)
//
//  one word per cycle while item_stall is low; a taken word goes to the input
//  register, then through encode and locate logic into the result register
//  result_stall holds the result register; item_stall rises only when both
//  registers are full and the result is stalled
//  reset empties both registers and clears the parity matrix
// ----------------------------------------------------------------------------
`include "linear_block_code_single_error_locator_top_defines.svh"

module linear_block_code_single_error_locator_top
    import lbcsel_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_write,
    input  matrix_t cfg_data,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    matrix_t matrix_reg, matrix_next;
    logic    stage_valid_reg, stage_valid_next;
    item_t   stage_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;

    logic    accept;
    logic    advance;
    coded_t  coded;
    pos_t    position;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = stage_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    lbcsel_encode u_encode (
        .parity_matrix (matrix_reg),
        .item          (stage_reg),
        .coded         (coded)
    );

    lbcsel_locate u_locate (
        .parity_matrix  (matrix_reg),
        .syndrome       (coded.syndrome),
        .error_position (position)
    );

    always_comb
    begin
        matrix_next       = cfg_write ? cfg_data : matrix_reg;
        stage_valid_next  = accept || (stage_valid_reg && !advance);
        result_valid_next = advance ? stage_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg       <= '0;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            matrix_reg       <= matrix_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // word registers carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= item;
        end
        if (advance && stage_valid_reg)
        begin
            result_reg <= '{codeword:       coded.codeword,
                            received_word:  coded.received_word,
                            syndrome:       coded.syndrome,
                            error_position: position};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LBCSEL_ASSERT_NEXT(a_accept_fills_stage, accept, stage_valid_reg, "accepted word not held in input register")
    `LBCSEL_ASSERT_SAME(a_single_flip, result_valid, $onehot(result.codeword ^ result.received_word), "received word differs from codeword in other than one bit")
    `LBCSEL_ASSERT_SAME(a_check_column, result_valid && (result.error_position > POS_BITS'(DATA_BITS)) && (result.error_position <= POS_BITS'(CODE_BITS)), $onehot(result.syndrome), "check column located for a syndrome of other than one bit")
    `LBCSEL_ASSERT_SAME(a_no_match, result_valid && (result.error_position == POS_BITS'(CODE_BITS + 1)), !$onehot(result.syndrome), "single bit syndrome left unmatched")

endmodule
